FILE: sv/c8ic_pkg.sv
// Shared types, codes and the hex font table of the CHIP-8 instruction core.
`default_nettype none
package c8ic_pkg;

  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned MEM_BYTES  = 4096;
  localparam int unsigned ROWS       = 32;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COLS       = 64;
  localparam int unsigned FONT_BYTES = 80;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNKNOWN   = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;
  localparam status_t ST_UNDERFLOW = 2'd3;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_EXEC  = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  // Glyph bytes for hex digits 0 to F, five rows each.
  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] b;
    case (idx)
      7'd0: b = 8'hF0;  7'd1: b = 8'h90;  7'd2: b = 8'h90;  7'd3: b = 8'h90;
      7'd4: b = 8'hF0;  7'd5: b = 8'h20;  7'd6: b = 8'h60;  7'd7: b = 8'h20;
      7'd8: b = 8'h20;  7'd9: b = 8'h70;  7'd10: b = 8'hF0; 7'd11: b = 8'h10;
      7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
      7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
      7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
      7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
      7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
      7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
      7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
      7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
      7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
      7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
      7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
      7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
      7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
      7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
      7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
      7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
      7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: sv/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core: sequencer, program store and framebuffer.
`default_nettype none
// The core takes one beat at a time and returns exactly one result beat for
// it. After reset it runs a clearing pass that loads zeros and the hex font
// into the program store; in_ready stays low during that pass, while
// configuration writes are taken as usual. A memory write or a screen row read
// goes straight to the result load. An instruction passes through the
// accepting cycle, two registered reads of the store's single read port, two
// register file reads, decode and execute, the timer step and the result load.
// A screen clear wipes one row per cycle, and a sprite draw adds a read and a
// write state per row drawn and a final read state, since each row byte is
// read through the same store port before it is XORed into the framebuffer. A
// finished result is held in an output register, so the core accepts the next
// beat while the previous result is still waiting.
module chip8_instruction_core #(
  parameter int unsigned START_ADDRESS = 512,
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned FONT_BASE     = 80
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [15:0] in_key_state,
  input  wire logic [7:0]  in_random_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [11:0]      out_program_counter,
  output logic             out_screen_changed,
  output logic             out_beep,
  output logic [63:0]      out_row_pixels,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned AW  = c8ic_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_F0, S_F1, S_F2, S_VX, S_VY, S_EXEC,
    S_CLR, S_DRD, S_DWR, S_TICK, S_DONE
  } state_t;

  state_t state_r;

  // Program store, single write port and one registered read port.
  logic [7:0]    mem [c8ic_pkg::MEM_BYTES];
  logic [7:0]    mem_rdata_r;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  logic [63:0]   frame_r [c8ic_pkg::ROWS];
  logic [7:0]    vreg_r [16];
  logic [AW-1:0] stack_r [STACK_DEPTH];
  logic [SPW-1:0] sp_r;
  logic [AW-1:0] pc_r, index_r;
  logic [7:0]    delay_r, sound_r;
  logic          vip_r;

  logic [AW-1:0] clr_cnt_r;
  logic [1:0]    op_r;
  logic [15:0]   keys_r;
  logic [7:0]    rnd_r;
  logic [15:0]   opc_r;
  logic [7:0]    vx_r, vy_r;
  logic [4:0]    cnt_r;
  logic          hit_r;

  logic [1:0]    res_status_r;
  logic          res_changed_r, res_beep_r;
  logic [63:0]   res_pixels_r;

  logic [1:0]    out_status_r;
  logic [AW-1:0] out_pc_r;
  logic          out_changed_r, out_beep_r, out_valid_r;
  logic [63:0]   out_pixels_r;

  logic          in_fire, cfg_wr;
  logic [3:0]    op_hi, op_x, op_y, op_n;
  logic [7:0]    op_nn;
  logic [AW-1:0] op_nnn, pc_next, pc_skip;
  logic [AW-1:0] clr_off;
  logic [5:0]    draw_row;
  logic [63:0]   pattern;
  logic [8:0]    sum9;
  logic [7:0]    tmr_d, tmr_s;
  logic [SPW-1:0] sp_dec;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {31'd0, vip_r};

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_program_counter = out_pc_r;
  assign out_screen_changed  = out_changed_r;
  assign out_beep            = out_beep_r;
  assign out_row_pixels      = out_pixels_r;

  assign op_hi   = opc_r[15:12];
  assign op_x    = opc_r[11:8];
  assign op_y    = opc_r[7:4];
  assign op_n    = opc_r[3:0];
  assign op_nn   = opc_r[7:0];
  assign op_nnn  = opc_r[11:0];
  assign pc_next = pc_r + AW'(2);
  assign pc_skip = pc_r + AW'(4);
  assign sp_dec  = sp_r - SPW'(1);
  assign sum9    = {1'b0, vx_r} + {1'b0, vy_r};

  // Sprite row position and the byte placed at column VX mod 64.
  assign draw_row = {1'b0, vy_r[4:0]} + {1'b0, cnt_r};
  assign pattern  = {mem_rdata_r, 56'd0} >> vx_r[5:0];

  // The clearing pass loads the font window and zeros elsewhere.
  assign clr_off = clr_cnt_r - AW'(FONT_BASE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_address;
    mem_wdata = in_write_data;
    if (state_r == S_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = (clr_cnt_r >= AW'(FONT_BASE) &&
                   clr_cnt_r < AW'(FONT_BASE + c8ic_pkg::FONT_BYTES)) ?
                  c8ic_pkg::font_byte(clr_off[6:0]) : 8'd0;
    end else if (in_fire && in_op == c8ic_pkg::OP_WRITE) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    case (state_r)
      S_F0:    mem_raddr = pc_r;
      S_F1:    mem_raddr = pc_next - AW'(1);
      default: mem_raddr = index_r + AW'(cnt_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // Timer step of an instruction that completed without error.
  assign tmr_d = delay_r - 8'((delay_r != 8'd0) ? 1 : 0);
  assign tmr_s = sound_r - 8'((sound_r != 8'd0) ? 1 : 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      vip_r       <= 1'b1;
      pc_r        <= AW'(START_ADDRESS);
      index_r     <= '0;
      sp_r        <= '0;
      delay_r     <= '0;
      sound_r     <= '0;
      for (int i = 0; i < 16; i++) begin
        vreg_r[i] <= '0;
      end
      for (int i = 0; i < int'(c8ic_pkg::ROWS); i++) begin
        frame_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        vip_r <= cfg_pwdata[0];
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(c8ic_pkg::MEM_BYTES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_r          <= in_op;
            keys_r        <= in_key_state;
            rnd_r         <= in_random_byte;
            res_status_r  <= c8ic_pkg::ST_OK;
            res_changed_r <= 1'b0;
            res_beep_r    <= 1'b0;
            res_pixels_r  <= '0;
            if (in_op == c8ic_pkg::OP_EXEC) begin
              state_r <= S_F0;
            end else begin
              if (in_op == c8ic_pkg::OP_READ && in_address < AW'(c8ic_pkg::ROWS)) begin
                res_pixels_r <= frame_r[in_address[c8ic_pkg::ROW_W-1:0]];
              end
              state_r <= S_DONE;
            end
          end
        end
        S_F0: state_r <= S_F1;
        S_F1: begin
          opc_r[15:8] <= mem_rdata_r;
          state_r     <= S_F2;
        end
        S_F2: begin
          opc_r[7:0] <= mem_rdata_r;
          state_r    <= S_VX;
        end
        S_VX: begin
          vx_r    <= vreg_r[op_x];
          state_r <= S_VY;
        end
        S_VY: begin
          // For BNNN the VY slot holds V0, which the original mode adds instead of VX.
          vy_r    <= (op_hi == 4'hB) ? vreg_r[4'h0] : vreg_r[op_y];
          cnt_r   <= '0;
          hit_r   <= 1'b0;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_TICK;
          pc_r    <= pc_next;
          case (op_hi)
            4'h0: begin
              if (opc_r == 16'h00E0) begin
                res_changed_r <= 1'b1;
                state_r       <= S_CLR;
              end else if (opc_r == 16'h00EE) begin
                if (sp_r == '0) begin
                  pc_r         <= pc_r;
                  res_status_r <= c8ic_pkg::ST_UNDERFLOW;
                  state_r      <= S_DONE;
                end else begin
                  pc_r <= stack_r[sp_dec[SIW-1:0]];
                  sp_r <= sp_dec;
                end
              end else begin
                pc_r         <= pc_r;
                res_status_r <= c8ic_pkg::ST_UNKNOWN;
                state_r      <= S_DONE;
              end
            end
            4'h1: pc_r <= op_nnn;
            4'h2: begin
              if (sp_r >= SPW'(STACK_DEPTH)) begin
                pc_r         <= pc_r;
                res_status_r <= c8ic_pkg::ST_OVERFLOW;
                state_r      <= S_DONE;
              end else begin
                stack_r[sp_r[SIW-1:0]] <= pc_next;
                sp_r <= sp_r + SPW'(1);
                pc_r <= op_nnn;
              end
            end
            4'h3: if (vx_r == op_nn) pc_r <= pc_skip;
            4'h4: if (vx_r != op_nn) pc_r <= pc_skip;
            4'h5: if (vx_r == vy_r) pc_r <= pc_skip;
            4'h6: vreg_r[op_x] <= op_nn;
            4'h7: vreg_r[op_x] <= vx_r + op_nn;
            4'h8: begin
              // The flag is written after the result, so it wins when X is F.
              case (op_n)
                4'h0: vreg_r[op_x] <= vy_r;
                4'h1: vreg_r[op_x] <= vx_r | vy_r;
                4'h2: vreg_r[op_x] <= vx_r & vy_r;
                4'h3: vreg_r[op_x] <= vx_r ^ vy_r;
                4'h4: begin
                  vreg_r[op_x] <= sum9[7:0];
                  vreg_r[15]   <= {7'd0, sum9[8]};
                end
                4'h5: begin
                  vreg_r[op_x] <= vx_r - vy_r;
                  vreg_r[15]   <= {7'd0, vx_r >= vy_r};
                end
                4'h6: begin
                  vreg_r[op_x] <= vip_r ? {1'b0, vy_r[7:1]} : {1'b0, vx_r[7:1]};
                  vreg_r[15]   <= {7'd0, vip_r ? vy_r[0] : vx_r[0]};
                end
                4'h7: begin
                  vreg_r[op_x] <= vy_r - vx_r;
                  vreg_r[15]   <= {7'd0, vy_r >= vx_r};
                end
                4'hE: begin
                  vreg_r[op_x] <= vip_r ? {vy_r[6:0], 1'b0} : {vx_r[6:0], 1'b0};
                  vreg_r[15]   <= {7'd0, vip_r ? vy_r[7] : vx_r[7]};
                end
                default: begin
                  pc_r         <= pc_r;
                  res_status_r <= c8ic_pkg::ST_UNKNOWN;
                  state_r      <= S_DONE;
                end
              endcase
            end
            4'h9: if (vx_r != vy_r) pc_r <= pc_skip;
            4'hA: index_r <= op_nnn;
            4'hB: pc_r <= op_nnn + AW'(vip_r ? vy_r : vx_r);
            4'hC: vreg_r[op_x] <= rnd_r & op_nn;
            4'hD: begin
              res_changed_r <= 1'b1;
              state_r       <= S_DRD;
            end
            4'hE: begin
              if (op_nn == 8'h9E) begin
                if (keys_r[vx_r[3:0]]) pc_r <= pc_skip;
              end else if (op_nn == 8'hA1) begin
                if (!keys_r[vx_r[3:0]]) pc_r <= pc_skip;
              end else begin
                pc_r         <= pc_r;
                res_status_r <= c8ic_pkg::ST_UNKNOWN;
                state_r      <= S_DONE;
              end
            end
            default: begin
              if (op_nn == 8'h07) begin
                vreg_r[op_x] <= delay_r;
              end else if (op_nn == 8'h15) begin
                delay_r <= vx_r;
              end else if (op_nn == 8'h18) begin
                sound_r <= vx_r;
              end else begin
                pc_r         <= pc_r;
                res_status_r <= c8ic_pkg::ST_UNKNOWN;
                state_r      <= S_DONE;
              end
            end
          endcase
        end
        S_CLR: begin
          frame_r[cnt_r] <= '0;
          cnt_r          <= cnt_r + 5'd1;
          if (cnt_r == 5'(c8ic_pkg::ROWS - 1)) begin
            state_r <= S_TICK;
          end
        end
        S_DRD: begin
          // The sprite byte at I plus the row count is read here.
          if ({1'b0, cnt_r} == {2'b00, op_n} || draw_row >= 6'(c8ic_pkg::ROWS)) begin
            vreg_r[15] <= {7'd0, hit_r};
            state_r    <= S_TICK;
          end else begin
            state_r <= S_DWR;
          end
        end
        S_DWR: begin
          if ((frame_r[draw_row[4:0]] & pattern) != 64'd0) begin
            hit_r <= 1'b1;
          end
          frame_r[draw_row[4:0]] <= frame_r[draw_row[4:0]] ^ pattern;
          cnt_r   <= cnt_r + 5'd1;
          state_r <= S_DRD;
        end
        S_TICK: begin
          delay_r    <= tmr_d;
          sound_r    <= tmr_s;
          res_beep_r <= (sound_r == 8'd1);
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_pc_r      <= pc_r;
            out_changed_r <= (res_status_r == c8ic_pkg::ST_OK) && res_changed_r;
            out_beep_r    <= res_beep_r;
            out_pixels_r  <= (op_r == c8ic_pkg::OP_READ) ? res_pixels_r : 64'd0;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/c8ic_checker.sv
// Port-level checks of the CHIP-8 instruction core and their binding.
`default_nettype none
module c8ic_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic        out_screen_changed,
  input wire logic        out_beep
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while one is in flight");

  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != c8ic_pkg::ST_OK |-> !out_screen_changed && !out_beep)
    else $error("failed instruction reported side effects");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("core not quiet after reset");

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_screen_changed(out_screen_changed), .out_beep(out_beep)
);
`default_nettype wire

FILE: tb/tb_chip8_instruction_core.sv
// Self-checking testbench for the CHIP-8 instruction core, with its scoreboard and stimulus.
module tb_chip8_instruction_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TARGET_ITEMS = 550;
  localparam logic [2:0] REG_QUIRKS = 3'd0;
  localparam logic [15:0] INSN_CLS = 16'h00E0;
  localparam logic [15:0] INSN_RET = 16'h00EE;
  localparam c8ic_pkg::op_t OP_NONE = 2'd3;

  // One expected result beat.
  typedef struct {
    c8ic_pkg::status_t status;
    logic [11:0] pc;
    logic        changed;
    logic        beep;
    logic [63:0] pixels;
  } chip8_result_t;

  // The scoreboard keeps its own copy of the machine. Every accepted input
  // beat is run through it at once, and the outcome waits in a queue until
  // the matching result beat leaves the core.
  class chip8_scoreboard;
    logic [7:0]  mem [4096];
    logic [7:0]  v [16];
    logic [11:0] index_reg;
    logic [11:0] pc;
    logic [11:0] stack [16];
    int          depth;
    logic [7:0]  delay_tmr;
    logic [7:0]  sound_tmr;
    logic [63:0] frame [32];
    logic        quirks;
    chip8_result_t results_due[$];
    int          errors;

    function void clear_machine();
      logic [639:0] glyphs;
      glyphs = {80'hF0909090F020602020_70, 80'hF010F080F0F010F010F0,
                80'h9090F01010F080F010F0, 80'hF080F090F0F010204040,
                80'hF090F090F0F090F010F0, 80'hF090F09090E090E090E0,
                80'hF0808080F0E0909090E0, 80'hF080F080F0F080F08080};
      foreach (mem[i]) mem[i] = 8'h00;
      for (int i = 0; i < 80; i++) mem[80 + i] = glyphs[639 - 8 * i -: 8];
      foreach (v[i]) v[i] = 8'h00;
      foreach (stack[i]) stack[i] = 12'h000;
      foreach (frame[i]) frame[i] = 64'h0;
      index_reg = 12'h000;
      pc = 12'd512;
      depth = 0;
      delay_tmr = 8'h00;
      sound_tmr = 8'h00;
      quirks = 1'b1;
      errors = 0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // Executes one opcode; the machine is left untouched on any error.
    function c8ic_pkg::status_t run_opcode(logic [15:0] opc, logic [15:0] keys,
                                           logic [7:0] rnd, output logic changed);
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx, vy, src;
      logic [11:0] nnn, nxt;
      logic [8:0]  sum;
      logic [63:0] pattern;
      logic        hit, key;
      int          row;
      x = opc[11:8];
      y = opc[7:4];
      n = opc[3:0];
      nn = opc[7:0];
      nnn = opc[11:0];
      nxt = pc + 12'd2;
      vx = v[x];
      vy = v[y];
      changed = 1'b0;
      case (opc[15:12])
        4'h0: begin
          if (opc == INSN_CLS) begin
            foreach (frame[i]) frame[i] = 64'h0;
            changed = 1'b1;
          end else if (opc == INSN_RET) begin
            if (depth == 0) return c8ic_pkg::ST_UNDERFLOW;
            depth--;
            nxt = stack[depth];
          end else begin
            return c8ic_pkg::ST_UNKNOWN;
          end
        end
        4'h1: nxt = nnn;
        4'h2: begin
          if (depth >= 16) return c8ic_pkg::ST_OVERFLOW;
          stack[depth] = nxt;
          depth++;
          nxt = nnn;
        end
        4'h3: if (vx == nn) nxt = nxt + 12'd2;
        4'h4: if (vx != nn) nxt = nxt + 12'd2;
        4'h5: if (vx == vy) nxt = nxt + 12'd2;
        4'h6: v[x] = nn;
        4'h7: v[x] = vx + nn;
        4'h8: begin
          case (n)
            4'h0: v[x] = vy;
            4'h1: v[x] = vx | vy;
            4'h2: v[x] = vx & vy;
            4'h3: v[x] = vx ^ vy;
            4'h4: begin
              sum = {1'b0, vx} + {1'b0, vy};
              v[x] = sum[7:0];
              v[15] = {7'd0, sum[8]};
            end
            4'h5: begin
              v[x] = vx - vy;
              v[15] = {7'd0, vx >= vy};
            end
            4'h6: begin
              src = quirks ? vy : vx;
              v[x] = src >> 1;
              v[15] = {7'd0, src[0]};
            end
            4'h7: begin
              v[x] = vy - vx;
              v[15] = {7'd0, vy >= vx};
            end
            4'hE: begin
              src = quirks ? vy : vx;
              v[x] = src << 1;
              v[15] = {7'd0, src[7]};
            end
            default: return c8ic_pkg::ST_UNKNOWN;
          endcase
        end
        4'h9: if (vx != vy) nxt = nxt + 12'd2;
        4'hA: index_reg = nnn;
        4'hB: nxt = nnn + {4'd0, quirks ? v[0] : vx};
        4'hC: v[x] = rnd & nn;
        4'hD: begin
          // Rows that fall below the bottom edge are clipped, as are pixels
          // shifted past the right edge.
          hit = 1'b0;
          for (int r = 0; r < n; r++) begin
            row = int'(vy[4:0]) + r;
            if (row < 32) begin
              pattern = {mem[index_reg + 12'(r)], 56'h0} >> vx[5:0];
              if ((frame[row] & pattern) != 64'h0) hit = 1'b1;
              frame[row] ^= pattern;
            end
          end
          v[15] = {7'd0, hit};
          changed = 1'b1;
        end
        4'hE: begin
          key = keys[vx[3:0]];
          if (nn == 8'h9E) begin
            if (key) nxt = nxt + 12'd2;
          end else if (nn == 8'hA1) begin
            if (!key) nxt = nxt + 12'd2;
          end else begin
            return c8ic_pkg::ST_UNKNOWN;
          end
        end
        default: begin
          if (nn == 8'h07) v[x] = delay_tmr;
          else if (nn == 8'h15) delay_tmr = vx;
          else if (nn == 8'h18) sound_tmr = vx;
          else return c8ic_pkg::ST_UNKNOWN;
        end
      endcase
      pc = nxt;
      return c8ic_pkg::ST_OK;
    endfunction

    function void note_input(c8ic_pkg::op_t op, logic [11:0] addr, logic [7:0] wdata,
                             logic [15:0] keys, logic [7:0] rnd);
      chip8_result_t res;
      logic changed;
      res.status = c8ic_pkg::ST_OK;
      res.changed = 1'b0;
      res.beep = 1'b0;
      res.pixels = 64'h0;
      if (op == c8ic_pkg::OP_WRITE) begin
        mem[addr] = wdata;
      end else if (op == c8ic_pkg::OP_READ) begin
        if (addr < 12'd32) res.pixels = frame[addr[4:0]];
      end else if (op == c8ic_pkg::OP_EXEC) begin
        res.status = run_opcode({mem[pc], mem[pc + 12'd1]}, keys, rnd, changed);
        if (res.status == c8ic_pkg::ST_OK) begin
          res.changed = changed;
          if (delay_tmr != 8'h00) delay_tmr--;
          if (sound_tmr != 8'h00) begin
            res.beep = (sound_tmr == 8'h01);
            sound_tmr--;
          end
        end
      end
      res.pc = pc;
      results_due.push_back(res);
    endfunction

    task report(string field, logic [63:0] want, logic [63:0] got);
      $display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    endtask

    task check_result(c8ic_pkg::status_t status, logic [11:0] pc_out, logic changed,
                      logic beep, logic [63:0] pixels);
      chip8_result_t res;
      if (results_due.size() == 0) begin
        report("unexpected result beat, status", 64'h0, 64'(status));
        return;
      end
      res = results_due.pop_front();
      if (status !== res.status) report("status", 64'(res.status), 64'(status));
      if (pc_out !== res.pc) report("program_counter", 64'(res.pc), 64'(pc_out));
      if (changed !== res.changed) report("screen_changed", 64'(res.changed), 64'(changed));
      if (beep !== res.beep) report("beep", 64'(res.beep), 64'(beep));
      if (pixels !== res.pixels) report("row_pixels", res.pixels, pixels);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [11:0] in_address;
  logic [7:0]  in_write_data;
  logic [15:0] in_key_state;
  logic [7:0]  in_random_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [11:0] out_program_counter;
  logic        out_screen_changed;
  logic        out_beep;
  logic [63:0] out_row_pixels;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  chip8_instruction_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_address(in_address),
    .in_write_data(in_write_data), .in_key_state(in_key_state),
    .in_random_byte(in_random_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_program_counter(out_program_counter), .out_screen_changed(out_screen_changed),
    .out_beep(out_beep), .out_row_pixels(out_row_pixels),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  chip8_scoreboard chip8_sb = new();
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 19;
  int unsigned recv_hold_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog. The limit lies above the slowest legal run, counting the
  // clearing pass after reset.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_chip8_instruction_core: FAIL");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the edge, before the core's own
  // updates land, so a beat is counted exactly when valid and ready were
  // both high. A requested hold-off keeps ready low for a counted stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      chip8_sb.check_result(out_status, out_program_counter, out_screen_changed,
                            out_beep, out_row_pixels);
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles = recv_hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one beat and holds it until the core takes it. The scoreboard is
  // told at the accepting edge. Valid stays high into the next beat unless a
  // random gap is drawn, so it is never lowered and raised in one step.
  task automatic send_beat(c8ic_pkg::op_t op, logic [11:0] addr, logic [7:0] wdata,
                           logic [15:0] keys, logic [7:0] rnd);
    int unsigned gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_address <= addr;
    in_write_data <= wdata;
    in_key_state <= keys;
    in_random_byte <= rnd;
    do @(posedge clk); while (!in_ready);
    chip8_sb.note_input(op, addr, wdata, keys, rnd);
    beats_sent++;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Places an opcode at the current program counter and runs it.
  task automatic run_insn(logic [15:0] opc);
    logic [11:0] at;
    at = chip8_sb.pc;
    send_beat(c8ic_pkg::OP_WRITE, at, opc[15:8], 16'($urandom), 8'($urandom));
    send_beat(c8ic_pkg::OP_WRITE, at + 12'd1, opc[7:0], 16'($urandom), 8'($urandom));
    send_beat(c8ic_pkg::OP_EXEC, 12'($urandom), 8'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chip8_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quirks(logic value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= REG_QUIRKS;
    cfg_pwdata <= {31'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    chip8_sb.quirks = value;
  endtask

  // Draws a mostly legal opcode, with a share of the undefined encodings.
  // Skip compares often use the register's current value so both outcomes
  // of the skip are seen.
  function automatic logic [15:0] pick_opcode();
    logic [3:0]  x, y, cls;
    logic [7:0]  nn;
    logic [3:0]  alu_ops [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
    logic [7:0]  f_ops [3] = '{8'h07, 8'h15, 8'h18};
    x = 4'($urandom);
    y = 4'($urandom);
    nn = 8'($urandom);
    cls = 4'($urandom);
    case (cls)
      4'h0: begin
        case ($urandom_range(3))
          0: return INSN_CLS;
          1, 2: return INSN_RET;
          default: return {4'h0, x, nn};
        endcase
      end
      4'h3, 4'h4: return {cls, x, ($urandom_range(1) ? chip8_sb.v[x] : nn)};
      4'h5, 4'h9: begin
        if ($urandom_range(1)) y = x;
        return {cls, x, y, 4'($urandom)};
      end
      4'h8: return {cls, x, y, ($urandom_range(7) == 0) ? 4'($urandom)
                                                       : alu_ops[$urandom_range(8)]};
      4'hA: return {cls, ($urandom_range(1) ? 12'(80 + 5 * $urandom_range(15))
                                            : 12'($urandom))};
      4'hD: return {cls, x, y, ($urandom_range(3) == 0) ? 4'hF : 4'($urandom)};
      4'hE: begin
        case ($urandom_range(4))
          0, 1: return {cls, x, 8'h9E};
          2, 3: return {cls, x, 8'hA1};
          default: return {cls, x, nn};
        endcase
      end
      4'hF: return {cls, x, ($urandom_range(4) == 0) ? nn : f_ops[$urandom_range(2)]};
      default: return {cls, x, nn};
    endcase
  endfunction

  // One random step: usually a whole instruction, otherwise a stray memory
  // write, a row read or an unused op code.
  task automatic random_step();
    case ($urandom_range(9))
      0: send_beat(c8ic_pkg::OP_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
                   8'($urandom));
      1: send_beat(c8ic_pkg::OP_READ, ($urandom_range(7) == 0) ? 12'($urandom)
                                                             : 12'($urandom_range(31)),
                   8'($urandom), 16'($urandom), 8'($urandom));
      2: if ($urandom_range(3) == 0)
           send_beat(OP_NONE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
         else
           run_insn(pick_opcode());
      default: run_insn(pick_opcode());
    endcase
  endtask

  initial begin
    chip8_sb.clear_machine();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = c8ic_pkg::OP_WRITE;
    in_address = 12'h000;
    in_write_data = 8'h00;
    in_key_state = 16'h0000;
    in_random_byte = 8'h00;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = REG_QUIRKS;
    cfg_pwdata = 32'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: the row at the bottom and just past it, the highest
    // address, the unused op code, a return with an empty stack, a screen
    // clear, a zero-height sprite, a font sprite and a read of row zero.
    send_beat(c8ic_pkg::OP_READ, 12'd31, 8'h00, 16'h0000, 8'h00);
    send_beat(c8ic_pkg::OP_READ, 12'd32, 8'hFF, 16'hFFFF, 8'hFF);
    send_beat(c8ic_pkg::OP_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_beat(c8ic_pkg::OP_READ, 12'hFFF, 8'h00, 16'h0000, 8'h00);
    send_beat(OP_NONE, 12'hABC, 8'h5A, 16'hA5A5, 8'h3C);
    run_insn(INSN_RET);
    run_insn(INSN_CLS);
    run_insn(16'hD120);
    run_insn(16'hA050);
    run_insn(16'hD01F);
    send_beat(c8ic_pkg::OP_READ, 12'd0, 8'h00, 16'h0000, 8'h00);
    wait_drained();

    // Four phases across both quirk settings. The second runs with no idling
    // at all, the third starts with a long receiver hold-off while beats keep
    // coming, and the last first forces a stack overflow, then an underflow.
    for (int phase = 0; phase < 4; phase++) begin
      write_quirks(phase[0]);
      send_idle_pct = (phase == 1) ? 0 : 19;
      recv_idle_pct = (phase == 1) ? 0 : 19;
      if (phase == 2) recv_hold_cycles = 400;
      if (phase == 3) begin
        for (int i = 0; i < 17; i++) run_insn({4'h2, 12'($urandom_range(4095))});
        // Hold the sender until every result so far has come back.
        wait_drained();
        for (int i = 0; i < 17; i++) run_insn(INSN_RET);
      end
      while (beats_sent < TARGET_ITEMS * (phase + 1) / 4) random_step();
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (chip8_sb.errors == 0 && chip8_sb.pending() == 0)
      $display("tb_chip8_instruction_core: PASS");
    else
      $display("tb_chip8_instruction_core: FAIL");
    $finish;
  end

endmodule
